// ----- src/ffsc_pkg.sv -----
// Flat-field sensitivity correction: shared types, state codes and constants.
// No dependencies; used by every module of the block.
package ffsc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DIVISOR_W  = 10;
  localparam int GAIN_W     = 26;
  localparam int QUOT_W     = 32;
  localparam int PROD_W     = 42;
  localparam int CORR_W     = 34;
  localparam int INDEX_W    = 12;
  localparam int OUT_SHIFT  = 8;

  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 10'd100;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  typedef struct packed {
    logic                command;
    logic                frame_start;
    logic [SAMPLE_W-1:0] map_sample;
    logic [SAMPLE_W-1:0] proj_pixel;
  } item_t;

  typedef struct packed {
    logic [CORR_W-1:0]  corrected_pixel;
    logic [GAIN_W-1:0]  gain_value;
    logic               below_threshold;
    logic               no_reference;
    logic [INDEX_W-1:0] pixel_index;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DIV,
    S_MUL,
    S_OUT
  } state_t;

endpackage

// ----- src/ffsc_map.sv -----
// Reference map store: single write port, single registered read port.
// Depends on ffsc_pkg for the sample width.
module ffsc_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [ffsc_pkg::SAMPLE_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [ffsc_pkg::SAMPLE_W-1:0] rdata
);

  logic [ffsc_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ffsc_div.sv -----
// Restoring divider: (num * 2^16) / den, one quotient bit per cycle.
// Depends on ffsc_pkg for widths; den must be nonzero when started.
module ffsc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ffsc_pkg::SAMPLE_W-1:0] num,
  input  logic [ffsc_pkg::SAMPLE_W-1:0] den,
  output logic                          valid,
  output logic [ffsc_pkg::QUOT_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(ffsc_pkg::QUOT_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [ffsc_pkg::SAMPLE_W-1:0] rem;
  logic [ffsc_pkg::SAMPLE_W-1:0] den_reg;
  logic [ffsc_pkg::SAMPLE_W:0]   shifted;
  logic [ffsc_pkg::SAMPLE_W:0]   diff;

  assign shifted = {rem, quotient[ffsc_pkg::QUOT_W-1]};
  assign diff    = shifted - {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ffsc_pkg::QUOT_W - 1)) begin
        busy  <= 1'b0;
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den_reg  <= den;
      quotient <= {num, {(ffsc_pkg::QUOT_W - ffsc_pkg::SAMPLE_W){1'b0}}};
    end else if (busy) begin
      if (!diff[ffsc_pkg::SAMPLE_W]) begin
        rem      <= diff[ffsc_pkg::SAMPLE_W-1:0];
        quotient <= {quotient[ffsc_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[ffsc_pkg::SAMPLE_W-1:0];
        quotient <= {quotient[ffsc_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/flat_field_sensitivity_correction.sv -----
// Flat-field sensitivity correction top level: sequencer, shared multiplier,
// map store and serial divider. Depends on ffsc_pkg, ffsc_map and ffsc_div.
//
// Usage:
//   Input transactions (item, item_valid/item_stall) carry either a load of
//   one reference map sample or a projection pixel to correct. Result
//   transactions (result, result_valid/result_stall) come one per correct
//   item and none per load item, in order.
//   A load item writes the sample to the map store and updates the
//   frame peak. A correct item reads the map entry at the running
//   read index, compares it with the peak through the multiplier, forms the
//   Q.16 gain in a 32-step restoring divider and multiplies the pixel by it.
//   Each correct item then steps through the states READ, CMP, DIV, MUL and
//   OUT, skipping DIV with a zero peak; the block takes the next item only
//   once it is back in IDLE.
//   item_stall is high while a correct item is in work. A stalled result sits
//   in the output register; a new item is still accepted, and its result
//   waits until the register drains.
//   Reset clears peak, load count, read index, and sets threshold to
//   100. The map store is not cleared; drive cfg_we only while idle.
module flat_field_sensitivity_correction #(
  parameter int MAP_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffsc_pkg::DIVISOR_W-1:0] cfg_wdata,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  ffsc_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output ffsc_pkg::result_t              result
);

  localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CW = $clog2(MAP_DEPTH + 1);

  ffsc_pkg::state_t state, state_next;

  logic [ffsc_pkg::DIVISOR_W-1:0] threshold;
  logic [ffsc_pkg::SAMPLE_W-1:0]  peak;
  logic [CW-1:0]                  loaded_count;
  logic [AW-1:0]                  read_index;

  logic [ffsc_pkg::SAMPLE_W-1:0]  s_val;
  logic [ffsc_pkg::SAMPLE_W-1:0]  proj;
  logic [AW-1:0]                  idx;
  logic [ffsc_pkg::GAIN_W-1:0]    gain;
  logic                           below;
  logic                           noref;
  logic [ffsc_pkg::PROD_W-1:0]    prod;

  logic                           accept;
  logic                           load_acc;
  logic                           corr_acc;
  logic                           wr_en;
  logic [CW-1:0]                  wr_pos;
  logic [AW-1:0]                  rd_addr;
  logic [ffsc_pkg::SAMPLE_W-1:0]  rd_data;
  logic                           above;
  logic                           div_start;
  logic [ffsc_pkg::SAMPLE_W-1:0]  div_num;
  logic [ffsc_pkg::SAMPLE_W-1:0]  div_den;
  logic                           div_valid;
  logic [ffsc_pkg::QUOT_W-1:0]    div_q;
  logic [ffsc_pkg::SAMPLE_W-1:0]  mul_a;
  logic [ffsc_pkg::GAIN_W-1:0]    mul_b;
  logic                           res_load;

  assign accept   = item_valid && !item_stall;
  assign load_acc = accept && (item.command == ffsc_pkg::CMD_LOAD);
  assign corr_acc = accept && (item.command == ffsc_pkg::CMD_CORRECT);
  assign wr_pos   = item.frame_start ? '0 : loaded_count;
  assign wr_en    = load_acc && (wr_pos < CW'(MAP_DEPTH));
  assign rd_addr  = item.frame_start ? '0 : read_index;
  assign above    = prod > ffsc_pkg::PROD_W'(peak);
  assign div_num  = above ? peak : s_val;
  assign div_den  = above ? s_val : peak;

  ffsc_map #(
    .DEPTH (MAP_DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_pos[AW-1:0]),
    .wdata (item.map_sample),
    .re    (corr_acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ffsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .valid    (div_valid),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    div_start  = 1'b0;
    res_load   = 1'b0;
    mul_a      = proj;
    mul_b      = gain;
    case (state)
      ffsc_pkg::S_IDLE: begin
        item_stall = 1'b0;
        if (corr_acc) begin
          state_next = ffsc_pkg::S_READ;
        end
      end
      ffsc_pkg::S_READ: begin
        mul_a      = rd_data;
        mul_b      = ffsc_pkg::GAIN_W'(threshold);
        state_next = ffsc_pkg::S_CMP;
      end
      ffsc_pkg::S_CMP: begin
        if (peak == '0) begin
          state_next = ffsc_pkg::S_MUL;
        end else begin
          div_start  = 1'b1;
          state_next = ffsc_pkg::S_DIV;
        end
      end
      ffsc_pkg::S_DIV: begin
        if (div_valid) begin
          state_next = ffsc_pkg::S_MUL;
        end
      end
      ffsc_pkg::S_MUL: begin
        state_next = ffsc_pkg::S_OUT;
      end
      ffsc_pkg::S_OUT: begin
        if (!result_valid || !result_stall) begin
          res_load   = 1'b1;
          state_next = ffsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= ffsc_pkg::DIVISOR_RESET;
      peak         <= '0;
      loaded_count <= '0;
      read_index   <= '0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (load_acc) begin
        if (wr_en) begin
          loaded_count <= wr_pos + 1'b1;
          if (item.frame_start || (item.map_sample > peak)) begin
            peak <= item.map_sample;
          end
        end else begin
          loaded_count <= wr_pos;
        end
      end
      if (corr_acc) begin
        read_index <= (rd_addr == AW'(MAP_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (corr_acc) begin
      proj <= item.proj_pixel;
      idx  <= rd_addr;
    end
    if (state == ffsc_pkg::S_READ || state == ffsc_pkg::S_MUL) begin
      prod <= ffsc_pkg::PROD_W'(mul_a) * ffsc_pkg::PROD_W'(mul_b);
    end
    if (state == ffsc_pkg::S_READ) begin
      s_val <= rd_data;
    end
    if (state == ffsc_pkg::S_CMP) begin
      noref <= (peak == '0);
      below <= (peak != '0) && !above;
      gain  <= '0;
    end
    if (state == ffsc_pkg::S_DIV && div_valid) begin
      gain <= div_q[ffsc_pkg::GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.corrected_pixel <=
        prod[ffsc_pkg::OUT_SHIFT +: ffsc_pkg::CORR_W];
      result.gain_value      <= gain;
      result.below_threshold <= below;
      result.no_reference    <= noref;
      result.pixel_index     <= ffsc_pkg::INDEX_W'(idx);
    end
  end

  a_noref_zero_gain: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.no_reference |->
      result.gain_value == '0 && !result.below_threshold)
    else $error("no-reference result carries a gain");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CW'(MAP_DEPTH))
    else $error("load count beyond map depth");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    read_index <= AW'(MAP_DEPTH - 1))
    else $error("read index beyond map depth");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    corr_acc |=> item_stall && state == ffsc_pkg::S_READ)
    else $error("correct item did not start the sequence");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == ffsc_pkg::S_DIV && !div_valid)
    else $error("divider result seen before it was formed");

endmodule
